FILE: src/imu_opc_pkg.sv
// Package for the three-axis PI offset calibrator: widths, constants,
// payload and control structs, and the offset word rounding function.
// No dependencies.
package imu_opc_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned ESumW    = 18;
  localparam int unsigned GainPW   = 22;
  localparam int unsigned GainIW   = 28;
  localparam int unsigned ProdPW   = ErrW + GainPW + 1;
  localparam int unsigned ProdIW   = ErrW + GainIW + 1;
  localparam int unsigned IntegW   = 48;
  localparam int unsigned SumW     = IntegW + 1;
  localparam int unsigned RoundW   = 8;
  localparam int unsigned GoodW    = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 28;
  localparam int unsigned OutDepth = 4;

  localparam int unsigned SamplesPerRoundDef = 100;

  localparam int GravityCounts = 16384;
  localparam int ESumReset     = 1000;
  localparam int ESumGood      = 100;
  localparam int ESumGoodGyro  = 5;
  localparam int MinCount      = 10;
  localparam int MinGood       = 10;
  localparam int GoodMax       = 127;

  localparam int unsigned ShAccel = 31;
  localparam int unsigned ShGyro  = 30;

  localparam logic [GainPW-1:0] GainPReset  = GainPW'(251658);
  localparam logic [GainIW-1:0] GainIReset  = GainIW'(19327352);
  localparam logic [RoundW-1:0] RoundsReset = RoundW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainP     = 2'd0,
    CfgGainI     = 2'd1,
    CfgAccelKind = 2'd2,
    CfgRounds    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ModeLoad   = 1'b0,
    ModeSample = 1'b1
  } mode_e;

  typedef struct packed {
    logic                    mode;
    logic signed [AxisW-1:0] axis_x;
    logic signed [AxisW-1:0] axis_y;
    logic signed [AxisW-1:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic signed [AxisW-1:0] offset_x;
    logic signed [AxisW-1:0] offset_y;
    logic signed [AxisW-1:0] offset_z;
    logic                    round_end;
    logic                    last;
    logic                    finished;
  } out_item_t;

  // Per-stage control that travels alongside the lane data.
  typedef struct packed {
    logic valid;
    logic is_load;
    logic end_round;
    logic finished;
  } opc_flag_t;

  // Round half away from zero by 2^31 (accel) or 2^30 (gyro), saturate to
  // int16, and in accel mode put back the kept low bit.
  function automatic logic [AxisW-1:0] opc_to_word(logic signed [SumW-1:0] v,
                                                   logic accel, logic kept);
    logic [SumW-1:0]  mag;
    logic [SumW-1:0]  q;
    logic [AxisW-1:0] w;
    mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
    if (accel) begin
      q = (mag + (SumW'(1) << (ShAccel - 1))) >> ShAccel;
    end else begin
      q = (mag + (SumW'(1) << (ShGyro - 1))) >> ShGyro;
    end
    if (v[SumW-1]) begin
      w = (q > SumW'(32768)) ? 16'h8000 : (~q[AxisW-1:0] + 16'd1);
    end else begin
      w = (q > SumW'(32767)) ? 16'h7fff : q[AxisW-1:0];
    end
    if (accel) begin
      w[0] = kept;
    end
    return w;
  endfunction

endpackage

FILE: src/imu_opc_ctrl.sv
// Front stage of the calibrator: error terms, error sum, round counters and
// working gains. Registers one pipeline slot for the lanes. Uses imu_opc_pkg.
module imu_opc_ctrl import imu_opc_pkg::*; #(
  parameter int unsigned SamplesPerRound = SamplesPerRoundDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_fire_i,
  input  in_item_t                 in_data_i,
  input  logic [GainPW-1:0]        gain_p_i,
  input  logic [GainIW-1:0]        gain_i_i,
  input  logic                     accel_i,
  input  logic [RoundW-1:0]        rounds_i,
  output opc_flag_t                flag_o,
  output logic [GainPW-1:0]        gain_p_o,
  output logic [GainIW-1:0]        gain_i_o,
  output logic signed [ErrW-1:0]   err_o [NumAxes],
  output logic                     kept_o [NumAxes]
);

  localparam int unsigned IdxW = $clog2(SamplesPerRound);

  logic [IdxW-1:0]   idx_q;
  logic [GoodW-1:0]  good_q;
  logic [RoundW-1:0] round_q;
  logic [GainPW-1:0] gp_now_q;
  logic [GainIW-1:0] gi_now_q;
  logic              done_q;
  logic              kept_q [NumAxes];

  opc_flag_t             flag_q;
  logic [GainPW-1:0]     gp_a_q;
  logic [GainIW-1:0]     gi_a_q;
  logic signed [ErrW-1:0] err_a_q [NumAxes];
  logic                  kept_a_q [NumAxes];

  logic signed [AxisW-1:0] axis [NumAxes];
  logic signed [ErrW-1:0]  word [NumAxes];
  logic signed [ErrW-1:0]  rd [NumAxes];
  logic signed [ErrW-1:0]  err [NumAxes];
  logic [ErrW-1:0]         mag [NumAxes];
  logic [ESumW-1:0]        esum;
  logic [IdxW-1:0]         c_base;
  logic [IdxW:0]           c_inc;
  logic                    good_inc;
  logic [GoodW-1:0]        good_nx;
  logic                    early;
  logic                    end_round;
  logic [RoundW-1:0]       round_nx;
  logic [RoundW-1:0]       target;
  logic                    done_nx;
  logic                    is_load;
  logic [GainPW+1:0]       gp_x3;
  logic [GainIW+1:0]       gi_x3;

  assign axis[0] = in_data_i.axis_x;
  assign axis[1] = in_data_i.axis_y;
  assign axis[2] = in_data_i.axis_z;
  assign is_load = (mode_e'(in_data_i.mode) == ModeLoad);

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      word[k] = ErrW'(axis[k]);
      rd[k]   = word[k];
      if (accel_i && (k == NumAxes - 1)) begin
        rd[k] = word[k] - ErrW'(GravityCounts);  // 1 g on z
      end
      err[k] = -rd[k];
      mag[k] = rd[k][ErrW-1] ? ErrW'(err[k]) : ErrW'(rd[k]);
    end
    esum = ESumW'(mag[0]) + ESumW'(mag[1]) + ESumW'(mag[2]);

    // last sample of a round with a large error restarts the count
    c_base = ((idx_q == IdxW'(SamplesPerRound - 1)) && (esum > ESumW'(ESumReset)))
             ? '0 : idx_q;
    good_inc = (esum < (accel_i ? ESumW'(ESumGood) : ESumW'(ESumGoodGyro))) &&
               (good_q != GoodW'(GoodMax));
    good_nx  = good_q + GoodW'(good_inc);
    early    = (esum < ESumW'(ESumGood)) && (c_base > IdxW'(MinCount)) &&
               (good_nx >= GoodW'(MinGood));
    c_inc    = {1'b0, c_base} + (IdxW + 1)'(1);
    end_round = early || (c_inc >= (IdxW + 1)'(SamplesPerRound));

    round_nx = round_q + RoundW'(1);
    target   = (rounds_i == '0) ? RoundW'(1) : rounds_i;
    done_nx  = (round_nx == '0) || (round_nx >= target);

    gp_x3 = {2'b00, gp_now_q} + {1'b0, gp_now_q, 1'b0};
    gi_x3 = {2'b00, gi_now_q} + {1'b0, gi_now_q, 1'b0};
  end

  // Calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      good_q   <= '0;
      round_q  <= '0;
      gp_now_q <= '0;
      gi_now_q <= '0;
      done_q   <= 1'b0;
      for (int k = 0; k < NumAxes; k++) kept_q[k] <= 1'b0;
    end else if (in_fire_i) begin
      if (is_load) begin
        gp_now_q <= gain_p_i;
        gi_now_q <= gain_i_i;
        idx_q    <= '0;
        good_q   <= '0;
        round_q  <= '0;
        done_q   <= 1'b0;
        for (int k = 0; k < NumAxes; k++) kept_q[k] <= accel_i & axis[k][0];
      end else if (!done_q) begin
        if (end_round) begin
          gp_now_q <= gp_x3[GainPW+1:2];
          gi_now_q <= gi_x3[GainIW+1:2];
          idx_q    <= '0;
          good_q   <= '0;
          round_q  <= round_nx;
          done_q   <= done_nx;
        end else begin
          idx_q  <= c_inc[IdxW-1:0];
          good_q <= good_nx;
        end
      end
    end
  end

  // Stage A slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else if (en_i) begin
      flag_q.valid     <= in_fire_i && (is_load || !done_q);
      flag_q.is_load   <= is_load;
      flag_q.end_round <= end_round;
      flag_q.finished  <= end_round && done_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gp_a_q <= gp_now_q;
      gi_a_q <= gi_now_q;
      for (int k = 0; k < NumAxes; k++) begin
        err_a_q[k]  <= is_load ? word[k] : err[k];
        kept_a_q[k] <= kept_q[k];
      end
    end
  end

  assign flag_o   = flag_q;
  assign gain_p_o = gp_a_q;
  assign gain_i_o = gi_a_q;
  assign err_o    = err_a_q;
  assign kept_o   = kept_a_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(SamplesPerRound - 1))
    else $error("sample index past end of round");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && is_load) |=> (!done_q && round_q == '0 && idx_q == '0))
    else $error("load did not clear round state");

  a_drop_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && !is_load && done_q) |=> !flag_q.valid)
    else $error("sample after finish entered the pipeline");
`endif

endmodule

FILE: src/imu_opc_lane.sv
// One axis of the calibrator datapath: P and I products, integrator with
// saturation, P+I sum and rounding to offset words. Uses imu_opc_pkg.
module imu_opc_lane import imu_opc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   accel_i,
  input  opc_flag_t              b_flag_i,
  input  logic signed [ErrW-1:0] err_i,
  input  logic                   kept_i,
  input  logic [GainPW-1:0]      gain_p_i,
  input  logic [GainIW-1:0]      gain_i_i,
  output logic [AxisW-1:0]       word_sum_o,
  output logic [AxisW-1:0]       word_int_o
);

  logic signed [ProdPW-1:0] prod_p;
  logic signed [ProdIW-1:0] prod_i;

  logic signed [ErrW-1:0]   err_b_q;
  logic                     kept_b_q;
  logic signed [ProdPW-1:0] prod_p_b_q;
  logic signed [ProdIW-1:0] prod_i_b_q;

  logic signed [IntegW-1:0] integ_q;
  logic signed [IntegW-1:0] pterm_c_q;
  logic                     kept_c_q;

  logic signed [SumW-1:0]   sum_d_q;
  logic signed [SumW-1:0]   int_d_q;
  logic                     kept_d_q;

  logic [AxisW-1:0]         word_sum_q;
  logic [AxisW-1:0]         word_int_q;

  logic signed [IntegW-1:0] seed;
  logic signed [SumW-1:0]   isum;
  logic signed [IntegW-1:0] isat;

  assign prod_p = err_i * $signed({1'b0, gain_p_i});
  assign prod_i = err_i * $signed({1'b0, gain_i_i});

  always_comb begin
    // offset word times 8 or 4, 28 fraction bits
    if (accel_i) begin
      seed = {err_b_q, 31'd0};
    end else begin
      seed = {err_b_q[ErrW-1], err_b_q, 30'd0};
    end
    isum = {integ_q[IntegW-1], integ_q} + SumW'(prod_i_b_q);
    if (isum[SumW-1] != isum[SumW-2]) begin
      isat = isum[SumW-1] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      isat = isum[IntegW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (en_i && b_flag_i.valid) begin
      integ_q <= b_flag_i.is_load ? seed : isat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_b_q    <= err_i;
      kept_b_q   <= kept_i;
      prod_p_b_q <= prod_p;
      prod_i_b_q <= prod_i;

      pterm_c_q  <= {prod_p_b_q, 8'd0};
      kept_c_q   <= kept_b_q;

      sum_d_q    <= {pterm_c_q[IntegW-1], pterm_c_q} + {integ_q[IntegW-1], integ_q};
      int_d_q    <= {integ_q[IntegW-1], integ_q};
      kept_d_q   <= kept_c_q;

      word_sum_q <= opc_to_word(sum_d_q, accel_i, kept_d_q);
      word_int_q <= opc_to_word(int_d_q, accel_i, kept_d_q);
    end
  end

  assign word_sum_o = word_sum_q;
  assign word_int_o = word_int_q;

endmodule

FILE: src/imu_opc_merge.sv
// Merge stage: builds the one or two result transfers of a sample from the
// three lanes and queues them for the output channel. Uses imu_opc_pkg.
module imu_opc_merge import imu_opc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  opc_flag_t        e_flag_i,
  input  logic [AxisW-1:0] word_sum_i [NumAxes],
  input  logic [AxisW-1:0] word_int_i [NumAxes],
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  out_item_t       buf_q [OutDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  out_item_t       res_first, res_end;
  logic            push, pop;
  logic [CntW-1:0] push_n;

  always_comb begin
    res_first.offset_x  = word_sum_i[0];
    res_first.offset_y  = word_sum_i[1];
    res_first.offset_z  = word_sum_i[2];
    res_first.round_end = 1'b0;
    res_first.last      = !e_flag_i.end_round;
    res_first.finished  = 1'b0;

    res_end.offset_x    = word_int_i[0];
    res_end.offset_y    = word_int_i[1];
    res_end.offset_z    = word_int_i[2];
    res_end.round_end   = 1'b1;
    res_end.last        = 1'b1;
    res_end.finished    = e_flag_i.finished;
  end

  assign push   = en_i && e_flag_i.valid && !e_flag_i.is_load;
  assign push_n = push ? (e_flag_i.end_round ? CntW'(2) : CntW'(1)) : '0;
  assign pop    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_n[PtrW-1:0];
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + push_n - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res_first;
      if (e_flag_i.end_round) begin
        buf_q[wr_q + PtrW'(1)] <= res_end;
      end
    end
  end

  assign room_o      = (cnt_q <= CntW'(OutDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rd_q];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(OutDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != '0) |-> (cnt_q <= CntW'(OutDepth - 2)))
    else $error("push without room for a round end pair");
`endif

endmodule

FILE: src/imu_offset_pi_calibrator_unit.sv
// A sample's first result passes through stage A, three lane stages, the
// word stage and then the result queue; a round end
// adds a second result right behind it. Throughput: one item per cycle; the
// pipeline stalls only while a sample waits in the last stage and the
// 4-entry result queue holds more than two transfers.
// Reset (async, active low) clears state and queue; config takes its defaults.
// Top level of the calibrator; uses imu_opc_pkg, imu_opc_ctrl, imu_opc_lane,
// imu_opc_merge.
module imu_offset_pi_calibrator_unit import imu_opc_pkg::*; #(
  parameter int unsigned SamplesPerRound = SamplesPerRoundDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Config registers
  logic [GainPW-1:0] gain_p_q;
  logic [GainIW-1:0] gain_i_q;
  logic              accel_q;
  logic [RoundW-1:0] rounds_q;

  // Pipeline control: one stall enable for every stage
  logic      en;
  logic      in_fire;
  logic      room;
  opc_flag_t flag_a, flag_b_q, flag_c_q, flag_d_q, flag_e_q;

  logic [GainPW-1:0]      gain_p_a;
  logic [GainIW-1:0]      gain_i_a;
  logic signed [ErrW-1:0] err_a [NumAxes];
  logic                   kept_a [NumAxes];
  logic [AxisW-1:0]       word_sum [NumAxes];
  logic [AxisW-1:0]       word_int [NumAxes];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GainPReset;
      gain_i_q <= GainIReset;
      accel_q  <= 1'b0;
      rounds_q <= RoundsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgGainP:     gain_p_q <= cfg_data_i[GainPW-1:0];
        CfgGainI:     gain_i_q <= cfg_data_i[GainIW-1:0];
        CfgAccelKind: accel_q  <= cfg_data_i[0];
        CfgRounds:    rounds_q <= cfg_data_i[RoundW-1:0];
        default:      ;
      endcase
    end
  end

  // Everything advances unless a sample sits in the last stage with no
  // queue room for a possible round-end pair.
  assign en         = !flag_e_q.valid || flag_e_q.is_load || room;
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;

  imu_opc_ctrl #(
    .SamplesPerRound(SamplesPerRound)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .gain_p_i  (gain_p_q),
    .gain_i_i  (gain_i_q),
    .accel_i   (accel_q),
    .rounds_i  (rounds_q),
    .flag_o    (flag_a),
    .gain_p_o  (gain_p_a),
    .gain_i_o  (gain_i_a),
    .err_o     (err_a),
    .kept_o    (kept_a)
  );

  // Flags follow the lane data through stages B to E
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_b_q <= '0;
      flag_c_q <= '0;
      flag_d_q <= '0;
      flag_e_q <= '0;
    end else if (en) begin
      flag_b_q <= flag_a;
      flag_c_q <= flag_b_q;
      flag_d_q <= flag_c_q;
      flag_e_q <= flag_d_q;
    end
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    imu_opc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .accel_i    (accel_q),
      .b_flag_i   (flag_b_q),
      .err_i      (err_a[g]),
      .kept_i     (kept_a[g]),
      .gain_p_i   (gain_p_a),
      .gain_i_i   (gain_i_a),
      .word_sum_o (word_sum[g]),
      .word_int_o (word_int[g])
    );
  end

  imu_opc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .e_flag_i    (flag_e_q),
    .word_sum_i  (word_sum),
    .word_int_i  (word_int),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (flag_e_q.valid && !room))
    else $error("input stalled without a blocked result");
`endif

endmodule
